// ----- sv/fwcrc_pkg.sv -----
// ============================================================================
// fwcrc_pkg
// Shared types, constants and CRC helper for the firmware image receiver.
// ============================================================================
`default_nettype none

package fwcrc_pkg;

  localparam int CHUNK_BYTES_DEF = 8;
  localparam int DATA_W = 64;
  localparam int CNT_W  = 4;
  localparam int SIZE_W = 22;
  localparam int CRC_W  = 32;
  localparam int ERR_W  = 16;
  localparam int ANN_W  = 32;
  localparam int ADDR_W = 3;

  localparam logic [CRC_W-1:0]  CRC_POLY     = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0]  CRC_INV      = 32'hFFFF_FFFF;
  localparam logic [SIZE_W-1:0] MIN_SIZE_RST = 22'd1024;
  localparam logic [SIZE_W-1:0] MAX_SIZE_RST = 22'd2097152;

  localparam logic REG_MIN_SIZE = 1'b0;
  localparam logic REG_MAX_SIZE = 1'b1;

  typedef enum logic [1:0] {
    ACT_START    = 2'd0,
    ACT_CHUNK    = 2'd1,
    ACT_FINALIZE = 2'd2,
    ACT_CANCEL   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_BUSY     = 3'd1,
    ST_SUCCESS  = 3'd2,
    ST_ERROR    = 3'd3,
    ST_SIZE_ERR = 3'd4,
    ST_PART_ERR = 3'd5
  } status_t;

  typedef struct packed {
    logic              accepted;
    status_t           status;
    logic [SIZE_W-1:0] received;
    logic [SIZE_W-1:0] expected;
    logic [CRC_W-1:0]  crc;
    logic [ERR_W-1:0]  err;
  } rsp_t;

  // Advances a raw CRC state over a number of zero bytes. Used only with
  // constant arguments to build the XOR matrices of the lanes and merge.
  function automatic logic [CRC_W-1:0] crc_advance(input logic [CRC_W-1:0] c,
                                                   input int nbytes);
    logic [CRC_W-1:0] x;
    x = c;
    for (int i = 0; i < 8 * nbytes; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

`default_nettype wire

// ----- sv/fwcrc_req_if.sv -----
// ============================================================================
// fwcrc_req_if
// Request channel of the firmware image receiver.
// ============================================================================
`default_nettype none

interface fwcrc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] announced_size;
  logic [63:0] chunk_bytes;
  logic [3:0]  chunk_count;
  logic        partition_ok;
  logic        flash_ok;
  logic [15:0] flash_error_code;

  modport source (
    output valid, action, announced_size, chunk_bytes, chunk_count,
           partition_ok, flash_ok, flash_error_code,
    input  ready
  );

  modport sink (
    input  valid, action, announced_size, chunk_bytes, chunk_count,
           partition_ok, flash_ok, flash_error_code,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/fwcrc_rsp_if.sv -----
// ============================================================================
// fwcrc_rsp_if
// Response channel of the firmware image receiver.
// ============================================================================
`default_nettype none

interface fwcrc_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [2:0]  session_status;
  logic [21:0] received_count;
  logic [21:0] expected_size;
  logic [31:0] running_crc;
  logic [15:0] recorded_error;

  modport source (
    output valid, accepted, session_status, received_count, expected_size,
           running_crc, recorded_error,
    input  ready
  );

  modport sink (
    input  valid, accepted, session_status, received_count, expected_size,
           running_crc, recorded_error,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/fwcrc_lane.sv -----
// ============================================================================
// fwcrc_lane
// One CRC lane: the contribution of one chunk byte, counted from the end.
// ============================================================================
`default_nettype none

module fwcrc_lane #(
  parameter int LANE = 0
) (
  input  wire logic [fwcrc_pkg::DATA_W-1:0] data,
  input  wire logic [fwcrc_pkg::CNT_W-1:0]  count,
  output logic      [fwcrc_pkg::CRC_W-1:0]  term
);
  import fwcrc_pkg::*;

  logic [CRC_W-1:0] cols [8];
  logic [CNT_W-1:0] pos;
  logic             active;
  logic [7:0]       byte_val;

  // Lane j takes the byte that is j places before the last one, so the
  // number of byte steps it still sees is fixed at j + 1.
  for (genvar k = 0; k < 8; k++) begin : g_col
    localparam logic [CRC_W-1:0] COL = crc_advance(CRC_W'(1) << k, LANE + 1);
    assign cols[k] = COL;
  end

  assign active   = count > CNT_W'(LANE);
  assign pos      = count - CNT_W'(LANE) - CNT_W'(1);
  assign byte_val = active ? data[{pos[2:0], 3'b000} +: 8] : 8'h00;

  always_comb begin
    term = '0;
    for (int k = 0; k < 8; k++) begin
      if (byte_val[k]) begin
        term = term ^ cols[k];
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/fwcrc_merge.sv -----
// ============================================================================
// fwcrc_merge
// Combines the lane terms with the advanced CRC state into the new CRC.
// ============================================================================
`default_nettype none

module fwcrc_merge #(
  parameter int LANES = fwcrc_pkg::CHUNK_BYTES_DEF
) (
  input  wire logic [fwcrc_pkg::CRC_W-1:0] crc_in,
  input  wire logic [fwcrc_pkg::CNT_W-1:0] count,
  input  wire logic [fwcrc_pkg::CRC_W-1:0] terms [LANES],
  output logic      [fwcrc_pkg::CRC_W-1:0] crc_out
);
  import fwcrc_pkg::*;

  logic [CRC_W-1:0] cols [LANES][CRC_W];
  logic [CRC_W-1:0] adv  [LANES];
  logic [CRC_W-1:0] raw;
  logic [CRC_W-1:0] state_term;
  logic [CRC_W-1:0] acc;

  for (genvar n = 0; n < LANES; n++) begin : g_len
    for (genvar k = 0; k < CRC_W; k++) begin : g_col
      localparam logic [CRC_W-1:0] COL = crc_advance(CRC_W'(1) << k, n + 1);
      assign cols[n][k] = COL;
    end
  end

  assign raw = crc_in ^ CRC_INV;

  always_comb begin
    for (int n = 0; n < LANES; n++) begin
      adv[n] = '0;
      for (int k = 0; k < CRC_W; k++) begin
        if (raw[k]) begin
          adv[n] = adv[n] ^ cols[n][k];
        end
      end
    end
  end

  always_comb begin
    state_term = raw;
    for (int n = 0; n < LANES; n++) begin
      if (count == CNT_W'(n + 1)) begin
        state_term = adv[n];
      end
    end
    acc = state_term;
    for (int j = 0; j < LANES; j++) begin
      acc = acc ^ terms[j];
    end
    crc_out = acc ^ CRC_INV;
  end

endmodule

`default_nettype wire

// ----- sv/firmware_image_receiver_crc32.sv -----
// ============================================================================
// firmware_image_receiver_crc32
// Firmware image receive session with a running reflected CRC-32.
// ============================================================================
// Responses are registered, into the skid entry while the output is held.
// Throughput: one request per cycle while the skid entry is empty; session
// state and CRC close their loop through the byte lanes and the merge stage.
// A two-entry output buffer lets a request enter while a response waits.
// Reset (synchronous): idle status, cleared counters, CRC and error code,
// size bounds back to 1024 and 2097152 bytes.
`default_nettype none

module firmware_image_receiver_crc32 #(
  parameter int CHUNK_BYTES = fwcrc_pkg::CHUNK_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  fwcrc_req_if.sink                           req,
  fwcrc_rsp_if.source                         rsp,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [fwcrc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);
  import fwcrc_pkg::*;

  status_t           status, status_next;
  logic [SIZE_W-1:0] expected_bytes, expected_next;
  logic [SIZE_W-1:0] received_bytes, received_next;
  logic [CRC_W-1:0]  crc_reg, crc_next;
  logic [ERR_W-1:0]  error_code_reg, error_code_next;
  logic [SIZE_W-1:0] min_size, max_size;
  logic              ok;

  logic              in_fire, out_fire, cfg_wr;
  action_t           act;
  logic [CNT_W-1:0]  cnt_cap;
  logic [SIZE_W:0]   sum;
  logic [CRC_W-1:0]  lane_terms [CHUNK_BYTES];
  logic [CRC_W-1:0]  crc_merged;
  rsp_t              rsp_next, out_data, skid_data;
  logic              out_valid, skid_valid;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MAX_SIZE) ? 32'(max_size) : 32'(min_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_size <= MIN_SIZE_RST;
      max_size <= MAX_SIZE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MIN_SIZE) begin
        min_size <= pwdata[SIZE_W-1:0];
      end else begin
        max_size <= pwdata[SIZE_W-1:0];
      end
    end
  end

  assign req.ready = !skid_valid;
  assign in_fire   = req.valid && req.ready;
  assign out_fire  = out_valid && rsp.ready;
  assign act       = action_t'(req.action);
  assign cnt_cap   = (req.chunk_count > CNT_W'(CHUNK_BYTES)) ? CNT_W'(CHUNK_BYTES)
                                                             : req.chunk_count;
  assign sum       = {1'b0, received_bytes} + (SIZE_W + 1)'(cnt_cap);

  for (genvar j = 0; j < CHUNK_BYTES; j++) begin : g_lane
    fwcrc_lane #(.LANE(j)) u_lane (
      .data  (req.chunk_bytes),
      .count (cnt_cap),
      .term  (lane_terms[j])
    );
  end

  fwcrc_merge #(.LANES(CHUNK_BYTES)) u_merge (
    .crc_in  (crc_reg),
    .count   (cnt_cap),
    .terms   (lane_terms),
    .crc_out (crc_merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      status         <= ST_IDLE;
      expected_bytes <= '0;
      received_bytes <= '0;
      crc_reg        <= '0;
      error_code_reg <= '0;
    end else begin
      status         <= status_next;
      expected_bytes <= expected_next;
      received_bytes <= received_next;
      crc_reg        <= crc_next;
      error_code_reg <= error_code_next;
    end
  end

  always_comb begin
    status_next     = status;
    expected_next   = expected_bytes;
    received_next   = received_bytes;
    crc_next        = crc_reg;
    error_code_next = error_code_reg;
    ok              = 1'b0;
    if (in_fire) begin
      unique case (act)
        ACT_START: begin
          priority if (req.announced_size < ANN_W'(min_size) ||
                       req.announced_size > ANN_W'(max_size)) begin
            status_next = ST_SIZE_ERR;
          end else if (!req.partition_ok) begin
            status_next = ST_PART_ERR;
          end else if (!req.flash_ok) begin
            status_next     = ST_ERROR;
            error_code_next = req.flash_error_code;
          end else begin
            expected_next = req.announced_size[SIZE_W-1:0];
            received_next = '0;
            crc_next      = '0;
            status_next   = ST_BUSY;
            ok            = 1'b1;
          end
        end
        ACT_CHUNK: begin
          if (status == ST_BUSY && cnt_cap != '0) begin
            priority if (sum > {1'b0, expected_bytes}) begin
              status_next = ST_SIZE_ERR;
            end else if (!req.flash_ok) begin
              status_next     = ST_ERROR;
              error_code_next = req.flash_error_code;
            end else begin
              received_next = sum[SIZE_W-1:0];
              crc_next      = crc_merged;
              ok            = 1'b1;
            end
          end
        end
        ACT_FINALIZE: begin
          if (status == ST_BUSY) begin
            priority if (received_bytes != expected_bytes) begin
              status_next = ST_SIZE_ERR;
            end else if (!req.flash_ok) begin
              status_next     = ST_ERROR;
              error_code_next = req.flash_error_code;
            end else if (!req.partition_ok) begin
              status_next     = ST_PART_ERR;
              error_code_next = req.flash_error_code;
            end else begin
              status_next = ST_SUCCESS;
              ok          = 1'b1;
            end
          end
        end
        ACT_CANCEL: begin
          status_next   = ST_IDLE;
          received_next = '0;
          ok            = 1'b1;
        end
        default: begin
          status_next = status;
        end
      endcase
    end
  end

  assign rsp_next = '{accepted: ok, status: status_next, received: received_next,
                      expected: expected_next, crc: crc_next, err: error_code_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_fire) begin
        out_data <= rsp_next;
      end
    end else if (in_fire) begin
      skid_data <= rsp_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.accepted       = out_data.accepted;
  assign rsp.session_status = out_data.status;
  assign rsp.received_count = out_data.received;
  assign rsp.expected_size  = out_data.expected;
  assign rsp.running_crc    = out_data.crc;
  assign rsp.recorded_error = out_data.err;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("Skid entry is held while the output register is empty.");

  a_resp_follows: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !out_valid) |=> out_valid)
    else $error("An accepted request did not produce a response.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    received_bytes <= expected_bytes)
    else $error("Received byte count exceeds the expected size.");

  a_crc_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(crc_reg))
    else $error("CRC changed without an accepted request.");

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the firmware image receiver with running CRC-32.
// Requests go in through the request channel with random gaps and responses
// are drained with random stalls. A scoreboard class predicts every response
// from its own copy of the session state, size bounds and CRC, and compares
// all six response fields in order. The size bounds are written over the
// APB port and read back between phases, including the extreme and crossed
// settings. A short directed list covers each rejection and failure path,
// then random well-formed sessions with some noise make up the bulk.
// ============================================================================

module tb;
  import fwcrc_pkg::*;

  typedef struct packed {
    action_t            action;
    logic [ANN_W-1:0]   size;
    logic [DATA_W-1:0]  data;
    logic [CNT_W-1:0]   count;
    logic               part_ok;
    logic               flash_ok;
    logic [ERR_W-1:0]   code;
  } request_t;

  class session_checker;
    logic [SIZE_W-1:0] min_size;
    logic [SIZE_W-1:0] max_size;
    status_t           status;
    logic [SIZE_W-1:0] expected;
    logic [SIZE_W-1:0] received;
    logic [CRC_W-1:0]  crc;
    logic [ERR_W-1:0]  err;
    rsp_t              status_due[$];
    int                errors;
    int                responses;
    int                successes;

    function new();
      min_size  = MIN_SIZE_RST;
      max_size  = MAX_SIZE_RST;
      status    = ST_IDLE;
      expected  = '0;
      received  = '0;
      crc       = '0;
      err       = '0;
      errors    = 0;
      responses = 0;
      successes = 0;
    endfunction

    function void set_bound(logic sel, logic [SIZE_W-1:0] value);
      if (sel == REG_MAX_SIZE) begin
        max_size = value;
      end else begin
        min_size = value;
      end
    endfunction

    function logic [CRC_W-1:0] crc_absorb(logic [CRC_W-1:0] prev,
                                          logic [DATA_W-1:0] bytes, int nbytes);
      logic [CRC_W-1:0] c;
      c = prev ^ CRC_INV;
      for (int i = 0; i < nbytes; i++) begin
        c = c ^ {24'd0, bytes[8*i +: 8]};
        for (int b = 0; b < 8; b++) begin
          c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
      end
      return c ^ CRC_INV;
    endfunction

    function void predict_status(request_t r);
      rsp_t due;
      int   n;
      logic ok;
      ok = 1'b0;
      case (r.action)
        ACT_START: begin
          if (r.size < {10'd0, min_size} || r.size > {10'd0, max_size}) begin
            status = ST_SIZE_ERR;
          end else if (!r.part_ok) begin
            status = ST_PART_ERR;
          end else if (!r.flash_ok) begin
            status = ST_ERROR;
            err = r.code;
          end else begin
            expected = r.size[SIZE_W-1:0];
            received = '0;
            crc = '0;
            status = ST_BUSY;
            ok = 1'b1;
          end
        end
        ACT_CHUNK: begin
          n = (r.count > CHUNK_BYTES_DEF) ? CHUNK_BYTES_DEF : int'(r.count);
          if (status == ST_BUSY && n != 0) begin
            if (int'(received) + n > int'(expected)) begin
              status = ST_SIZE_ERR;
            end else if (!r.flash_ok) begin
              status = ST_ERROR;
              err = r.code;
            end else begin
              received = SIZE_W'(int'(received) + n);
              crc = crc_absorb(crc, r.data, n);
              ok = 1'b1;
            end
          end
        end
        ACT_FINALIZE: begin
          if (status == ST_BUSY) begin
            if (received != expected) begin
              status = ST_SIZE_ERR;
            end else if (!r.flash_ok) begin
              status = ST_ERROR;
              err = r.code;
            end else if (!r.part_ok) begin
              status = ST_PART_ERR;
              err = r.code;
            end else begin
              status = ST_SUCCESS;
              ok = 1'b1;
            end
          end
        end
        default: begin
          status = ST_IDLE;
          received = '0;
          ok = 1'b1;
        end
      endcase
      due.accepted = ok;
      due.status   = status;
      due.received = received;
      due.expected = expected;
      due.crc      = crc;
      due.err      = err;
      status_due.push_back(due);
    endfunction

    function void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      end
    endfunction

    function void check_status(rsp_t got);
      rsp_t want;
      responses++;
      if (status_due.size() == 0) begin
        errors++;
        $display("%0t ns: response with no request waiting, status %0d",
                 $time, got.status);
        return;
      end
      want = status_due.pop_front();
      if (want.accepted && want.status == ST_SUCCESS) begin
        successes++;
      end
      check_field("accepted", 32'(want.accepted), 32'(got.accepted));
      check_field("session_status", 32'(want.status), 32'(got.status));
      check_field("received_count", 32'(want.received), 32'(got.received));
      check_field("expected_size", 32'(want.expected), 32'(got.expected));
      check_field("running_crc", want.crc, got.crc);
      check_field("recorded_error", 32'(want.err), 32'(got.err));
    endfunction
  endclass

  localparam int HOLD_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  fwcrc_req_if req_ch ();
  fwcrc_rsp_if rsp_ch ();

  session_checker sb;
  int sent;
  int settings_used;
  bit tx_calm;
  bit rx_calm;
  bit hold_rsp;

  firmware_image_receiver_crc32 i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin : monitor
    request_t r;
    rsp_t     got;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        r.action   = action_t'(req_ch.action);
        r.size     = req_ch.announced_size;
        r.data     = req_ch.chunk_bytes;
        r.count    = req_ch.chunk_count;
        r.part_ok  = req_ch.partition_ok;
        r.flash_ok = req_ch.flash_ok;
        r.code     = req_ch.flash_error_code;
        sb.predict_status(r);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.accepted = rsp_ch.accepted;
        got.status   = status_t'(rsp_ch.session_status);
        got.received = rsp_ch.received_count;
        got.expected = rsp_ch.expected_size;
        got.crc      = rsp_ch.running_crc;
        got.err      = rsp_ch.recorded_error;
        sb.check_status(got);
      end
    end
  end

  function automatic int idle_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic request_t mk(action_t a, logic [ANN_W-1:0] size,
                                  logic [DATA_W-1:0] data, logic [CNT_W-1:0] count,
                                  logic part_ok, logic flash_ok, logic [ERR_W-1:0] code);
    request_t r;
    r.action   = a;
    r.size     = size;
    r.data     = data;
    r.count    = count;
    r.part_ok  = part_ok;
    r.flash_ok = flash_ok;
    r.code     = code;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.action   = action_t'($urandom_range(0, 3));
    r.size     = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 64);
    r.data     = {$urandom, $urandom};
    r.count    = CNT_W'($urandom_range(0, 15));
    r.part_ok  = 1'($urandom_range(0, 1));
    r.flash_ok = 1'($urandom_range(0, 1));
    r.code     = ERR_W'($urandom_range(0, 65535));
    return r;
  endfunction

  // Offers one request, holds it until taken, then idles for a random gap.
  task automatic issue(request_t r);
    int gap;
    gap = idle_len(tx_calm);
    req_ch.valid            <= 1'b1;
    req_ch.action           <= r.action;
    req_ch.announced_size   <= r.size;
    req_ch.chunk_bytes      <= r.data;
    req_ch.chunk_count      <= r.count;
    req_ch.partition_ok     <= r.part_ok;
    req_ch.flash_ok         <= r.flash_ok;
    req_ch.flash_error_code <= r.code;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.status_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_bound(logic sel, logic [SIZE_W-1:0] value);
    logic [9:0] junk;
    junk = 10'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {junk, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_bound(sel, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_field("register read-back", 32'(value), 32'(prdata[SIZE_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_bounds(logic [SIZE_W-1:0] lo, logic [SIZE_W-1:0] hi);
    write_bound(REG_MIN_SIZE, lo);
    write_bound(REG_MAX_SIZE, hi);
    settings_used++;
  endtask

  // A well-formed session with random content, sometimes broken on purpose.
  task automatic run_session(int lo, int hi);
    request_t r;
    int       remaining;
    int       n;
    r = random_request();
    r.action   = ACT_START;
    r.size     = $urandom_range(lo, hi);
    r.part_ok  = ($urandom_range(0, 19) != 0);
    r.flash_ok = ($urandom_range(0, 19) != 0);
    remaining  = r.size;
    issue(r);
    while (remaining > 0) begin
      r = random_request();
      r.action = ACT_CHUNK;
      n = $urandom_range(1, CHUNK_BYTES_DEF);
      if (n > remaining && $urandom_range(0, 9) != 0) begin
        n = remaining;
      end
      r.count = (n == CHUNK_BYTES_DEF && $urandom_range(0, 3) == 0) ?
                CNT_W'($urandom_range(9, 15)) : CNT_W'(n);
      r.flash_ok = ($urandom_range(0, 49) != 0);
      issue(r);
      remaining -= n;
      if ($urandom_range(0, 39) == 0) begin
        issue(random_request());
      end
    end
    r = random_request();
    r.action   = ($urandom_range(0, 9) == 0) ? ACT_CANCEL : ACT_FINALIZE;
    r.part_ok  = ($urandom_range(0, 14) != 0);
    r.flash_ok = ($urandom_range(0, 14) != 0);
    issue(r);
    if ($urandom_range(0, 11) == 0) begin
      wait_drained();
    end
  endtask

  initial begin
    int r;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
      end else begin
        r = idle_len(rx_calm);
        if (r > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (r) @(posedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sb = new();
    sent = 0;
    settings_used = 1;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    hold_rsp = 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    req_ch.valid            <= 1'b0;
    req_ch.action           <= ACT_START;
    req_ch.announced_size   <= '0;
    req_ch.chunk_bytes      <= '0;
    req_ch.chunk_count      <= '0;
    req_ch.partition_ok     <= 1'b0;
    req_ch.flash_ok         <= 1'b0;
    req_ch.flash_error_code <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Start checks against the reset bounds, and requests out of session.
    issue(mk(ACT_START, 32'd1023, '0, 4'd0, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_START, 32'hFFFF_FFFF, '0, 4'd0, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_START, 32'd2097153, '0, 4'd0, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_START, 32'd1024, '0, 4'd0, 1'b0, 1'b1, 16'h0001));
    issue(mk(ACT_START, 32'd1024, '0, 4'd0, 1'b1, 1'b0, 16'hFFFF));
    issue(mk(ACT_CHUNK, 32'd0, 64'h1122_3344_5566_7788, 4'd4, 1'b1, 1'b1, 16'h0));
    issue(mk(ACT_FINALIZE, 32'd0, '0, 4'd0, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_START, 32'd2097152, '0, 4'd0, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_CHUNK, 32'd0, '1, 4'd0, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_CHUNK, 32'd0, '1, 4'd15, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_FINALIZE, 32'd0, '0, 4'd0, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_CANCEL, 32'd0, '0, 4'd0, 1'b0, 1'b0, 16'h0000));
    wait_drained();

    // Short sessions: overrun, failed write, failed end and boot select.
    set_bounds(22'd0, 22'd20);
    issue(mk(ACT_START, 32'd0, '0, 4'd0, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_FINALIZE, 32'd0, '0, 4'd0, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_START, 32'd12, '0, 4'd0, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_CHUNK, 32'd0, '0, 4'd8, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_CHUNK, 32'd0, '1, 4'd8, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_START, 32'd12, '0, 4'd0, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_CHUNK, 32'd0, 64'hA5, 4'd4, 1'b1, 1'b0, 16'h0000));
    issue(mk(ACT_START, 32'd4, '0, 4'd0, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_CHUNK, 32'd0, 64'h3132_3334, 4'd4, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_FINALIZE, 32'd0, '0, 4'd0, 1'b1, 1'b0, 16'h1234));
    issue(mk(ACT_START, 32'd4, '0, 4'd0, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_CHUNK, 32'd0, 64'hDEAD_BEEF, 4'd4, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_FINALIZE, 32'd0, '0, 4'd0, 1'b0, 1'b1, 16'hBEEF));
    issue(mk(ACT_START, 32'd20, '0, 4'd0, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_CHUNK, 32'd0, {$urandom, $urandom}, 4'd8, 1'b1, 1'b1, 16'h0));
    issue(mk(ACT_CHUNK, 32'd0, {$urandom, $urandom}, 4'd8, 1'b1, 1'b1, 16'h0));
    issue(mk(ACT_CHUNK, 32'd0, {$urandom, $urandom}, 4'd4, 1'b1, 1'b1, 16'h0));
    issue(mk(ACT_FINALIZE, 32'd0, '0, 4'd0, 1'b1, 1'b1, 16'h0000));
    wait_drained();

    set_bounds(22'd0, 22'd48);
    while (sent < 650) begin
      run_session(0, 52);
    end
    wait_drained();

    // Crossed bounds: every start must be refused on size.
    set_bounds(22'h3F_FFFF, 22'd0);
    repeat (50) issue(random_request());
    wait_drained();

    set_bounds(22'd24, 22'd24);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    while (sent < 900) begin
      run_session(20, 28);
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    wait_drained();

    set_bounds(22'd0, 22'h3F_FFFF);
    issue(mk(ACT_START, 32'h003F_FFFF, '0, 4'd0, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_CHUNK, 32'd0, {$urandom, $urandom}, 4'd8, 1'b1, 1'b1, 16'h0));
    issue(mk(ACT_CANCEL, 32'd0, '0, 4'd0, 1'b1, 1'b1, 16'h0000));
    issue(mk(ACT_START, 32'h0040_0000, '0, 4'd0, 1'b1, 1'b1, 16'h0000));

    // The receiver stops while the sender keeps pushing, so the input backs up.
    hold_rsp = 1'b1;
    tx_calm = 1'b1;
    repeat (3) run_session(8, 40);
    tx_calm = 1'b0;
    wait_drained();
    while (sent < 1400) begin
      run_session(0, 40);
    end
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Checked %0d responses to %0d requests over %0d size-bound settings.",
             sb.responses, sent, settings_used);
    $display("%0d sessions finalized successfully; one long response stall was included.",
             sb.successes);
    if (sb.errors == 0 && sb.status_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
